// ===== rtl/nmp_pkg.sv =====
// ----------------------------------------------------------------------------
// nmp_pkg
// Shared types, constants and arithmetic helpers for the Newmark predictor.
// ----------------------------------------------------------------------------
package nmp_pkg;

  // freedoms per node; slots at or above this pass through
  localparam int DOFS_PER_NODE = 4;

  // Q16.16 constants
  localparam logic signed [18:0] Q_ONE_19   = 19'sd65536;
  localparam logic signed [17:0] Q_ONE_18   = 18'sd65536;
  localparam logic signed [31:0] TEMP_CLAMP = 32'sd6553600;  // 100.0
  localparam logic signed [31:0] S32_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN    = 32'sh8000_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DYNAMIC_MODE  = 3'd0,
    REG_THERMAL_MODE  = 3'd1,
    REG_HAS_PREV_INC  = 3'd2,
    REG_DISCONTINUITY = 3'd3,
    REG_STEP_TIME     = 3'd4,
    REG_NEWMARK_BETA  = 3'd5,
    REG_NEWMARK_GAMMA = 3'd6
  } reg_idx_t;

  // thermal mode codes (code 3 acts as coupled)
  localparam logic [1:0] THERM_MECH    = 2'd0;
  localparam logic [1:0] THERM_ONLY    = 2'd1;
  localparam logic [1:0] THERM_COUPLED = 2'd2;

  // live configuration and derived coefficients
  typedef struct packed {
    logic                dynamic_mode;
    logic [1:0]          thermal_mode;
    logic                has_prev_inc;
    logic                discontinuity;
    logic [30:0]         step_time;
    logic signed [31:0]  disp_coef;
    logic signed [31:0]  vel_coef;
  } cfg_t;

  // magnitude of a signed 32-bit word; -2^31 gives 2^31
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // round a Q32.32 magnitude to Q16.16 (ties away from zero), apply sign
  function automatic logic signed [48:0] rnd_sign(input logic [63:0] p, input logic neg);
    logic [63:0] r;
    logic signed [48:0] m;
    r = p + 64'd32768;
    m = $signed({1'b0, r[63:16]});
    return neg ? -m : m;
  endfunction

  // saturate a wide signed sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [48:0] hi;
    logic signed [48:0] lo;
    hi = 49'(S32_MAX);
    lo = 49'(S32_MIN);
    if (v > hi) return S32_MAX;
    if (v < lo) return S32_MIN;
    return v[31:0];
  endfunction

endpackage

// ===== rtl/nmp_cfg.sv =====
// ----------------------------------------------------------------------------
// nmp_cfg
// Configuration registers and multi-cycle coefficient sequencer.
// ----------------------------------------------------------------------------
module nmp_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                busy,
  output nmp_pkg::cfg_t       cfg
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SQ   = 6'b000010,
    ST_RND  = 6'b000100,
    ST_LO   = 6'b001000,
    ST_HI   = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic               dyn_r, hprev_r, disc_r;
  logic [1:0]         therm_r;
  logic [30:0]        step_r;
  logic [16:0]        beta_r, gamma_r;
  logic signed [31:0] disp_coef_r, disp_coef_nxt;
  logic signed [31:0] vel_coef_r, vel_coef_nxt;
  logic [61:0]        sq_r;
  logic [47:0]        vprod_r;
  logic [46:0]        dt2_r;
  logic [64:0]        acc_r, acc_nxt;

  logic signed [18:0] mb;
  logic [17:0]        mag_b;
  logic signed [17:0] mg;
  logic [16:0]        mag_g;
  logic [41:0]        lo_prod;
  logic [40:0]        hi_prod;
  logic [61:0]        sq_prod;
  logic [47:0]        v_prod;
  logic [61:0]        sq_rnd;
  logic [47:0]        v_rnd;
  logic [64:0]        f_rnd;
  logic [47:0]        pm;
  logic               wr;

  assign cfg_ready = (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign wr        = cfg_valid && cfg_ready;

  // 1 - 2*beta and 1 - gamma
  assign mb    = nmp_pkg::Q_ONE_19 - $signed({1'b0, beta_r, 1'b0});
  assign mag_b = mb[18] ? 18'(-mb) : 18'(mb);
  assign mg    = nmp_pkg::Q_ONE_18 - $signed({1'b0, gamma_r});
  assign mag_g = mg[17] ? 17'(-mg) : 17'(mg);

  assign sq_prod = step_r * step_r;
  assign v_prod  = mag_g * step_r;
  assign lo_prod = dt2_r[23:0] * mag_b;
  assign hi_prod = dt2_r[46:24] * mag_b;
  assign sq_rnd  = sq_r + 62'd32768;
  assign v_rnd   = vprod_r + 48'd32768;
  assign f_rnd   = acc_r + 65'd65536;
  assign pm      = f_rnd[64:17];

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    disp_coef_nxt = disp_coef_r;
    vel_coef_nxt  = vel_coef_r;
    case (state_r)
      ST_IDLE: if (wr) state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_RND;
      ST_RND: begin
        // |1-gamma| * step_time stays below 2^31 after rounding
        vel_coef_nxt = mg[17] ? -$signed(v_rnd[47:16]) : $signed(v_rnd[47:16]);
        state_nxt    = ST_LO;
      end
      ST_LO: begin
        acc_nxt   = 65'(lo_prod);
        state_nxt = ST_HI;
      end
      ST_HI: begin
        acc_nxt   = acc_r + {hi_prod, 24'd0};
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (mb[18]) begin
          disp_coef_nxt = (|pm[47:31]) ? nmp_pkg::S32_MIN : -$signed(pm[31:0]);
        end else begin
          disp_coef_nxt = (|pm[47:31]) ? nmp_pkg::S32_MAX : $signed(pm[31:0]);
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dyn_r       <= 1'b0;
      therm_r     <= nmp_pkg::THERM_MECH;
      hprev_r     <= 1'b0;
      disc_r      <= 1'b0;
      step_r      <= '0;
      beta_r      <= 17'd16384;
      gamma_r     <= 17'd32768;
      disp_coef_r <= '0;
      vel_coef_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      disp_coef_r <= disp_coef_nxt;
      vel_coef_r  <= vel_coef_nxt;
      if (wr) begin
        case (nmp_pkg::reg_idx_t'(cfg_index))
          nmp_pkg::REG_DYNAMIC_MODE:  dyn_r   <= cfg_data[0];
          nmp_pkg::REG_THERMAL_MODE:  therm_r <= cfg_data[1:0];
          nmp_pkg::REG_HAS_PREV_INC:  hprev_r <= cfg_data[0];
          nmp_pkg::REG_DISCONTINUITY: disc_r  <= cfg_data[0];
          nmp_pkg::REG_STEP_TIME:     step_r  <= cfg_data[30:0];
          nmp_pkg::REG_NEWMARK_BETA:  beta_r  <= cfg_data[16:0];
          nmp_pkg::REG_NEWMARK_GAMMA: gamma_r <= cfg_data[16:0];
          default: ;
        endcase
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (state_r == ST_SQ) begin
      sq_r    <= sq_prod;
      vprod_r <= v_prod;
    end
    if (state_r == ST_RND) dt2_r <= {1'b0, sq_rnd[61:16]};
  end

  always_comb begin
    cfg.dynamic_mode  = dyn_r;
    cfg.thermal_mode  = therm_r;
    cfg.has_prev_inc  = hprev_r;
    cfg.discontinuity = disc_r;
    cfg.step_time     = step_r;
    cfg.disp_coef     = disp_coef_r;
    cfg.vel_coef      = vel_coef_r;
  end

endmodule

// ===== rtl/nmp_pipe.sv =====
// ----------------------------------------------------------------------------
// nmp_pipe
// Four-register prediction pipeline: input, products, sums, result.
// ----------------------------------------------------------------------------
module nmp_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  nmp_pkg::cfg_t       cfg,
  input  logic                in_fire,
  output logic                pipe_ready,
  input  logic [1:0]          in_slot,
  input  logic signed [31:0]  in_value,
  input  logic signed [31:0]  in_velocity,
  input  logic signed [31:0]  in_accel,
  input  logic                in_active,
  input  logic                in_last,
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [31:0]  out_value,
  output logic signed [31:0]  out_velocity,
  output logic signed [31:0]  out_accel,
  output logic [30:0]         out_max_mech,
  output logic [30:0]         out_max_temp,
  output logic                out_last
);

  logic en1, en2, en3, eno;

  // stage 1: input register
  logic               v1_r, act1_r, last1_r;
  logic [1:0]         slot1_r;
  logic signed [31:0] val1_r, vel1_r, acc1_r;

  // stage 2: products
  logic               v2_r, act2_r, last2_r, app2_r, nm2_r, tmp2_r;
  logic               n1_r, n2_r, n3_r;
  logic signed [31:0] val2_r, vel2_r, acc2_r;
  logic [62:0]        p1_r;
  logic [63:0]        p2_r, p3_r;

  // stage 3: sums
  logic               v3_r, act3_r, last3_r, app3_r, nm3_r, tmp3_r;
  logic signed [31:0] val3_r, vel3_r, acc3_r;
  logic signed [48:0] inc3_r, vs3_r;

  // result and running maxima
  logic               vo_r;
  logic [30:0]        mech_max_r, temp_max_r;

  // stage 1 decode and multiply
  logic        therm_only, temp_slot, touched, newmark, apply;
  logic [31:0] vel_mag, acc_mag, dc_mag, vc_mag;
  logic [62:0] p1;
  logic [63:0] p2, p3;

  // stage 2 sums
  logic signed [48:0] t1, t2, t3;

  // stage 3 finish
  logic signed [31:0] inc_s, inc_c, nval;
  logic [31:0]        inc_mag;
  logic [30:0]        a31, mech_upd, temp_upd;

  assign eno        = !vo_r || out_ready;
  assign en3        = !v3_r || eno;
  assign en2        = !v2_r || en3;
  assign en1        = !v1_r || en2;
  assign pipe_ready = en1;
  assign out_valid  = vo_r;

  always_comb begin
    therm_only = (cfg.thermal_mode == nmp_pkg::THERM_ONLY);
    temp_slot  = (slot1_r == 2'd0) && (cfg.thermal_mode != nmp_pkg::THERM_MECH);
    touched    = (32'(slot1_r) < nmp_pkg::DOFS_PER_NODE) && (!therm_only || slot1_r == 2'd0);
    newmark    = cfg.dynamic_mode && !therm_only;
    apply      = touched && (cfg.dynamic_mode || (cfg.has_prev_inc && !cfg.discontinuity));
    vel_mag    = nmp_pkg::mag32(vel1_r);
    acc_mag    = nmp_pkg::mag32(acc1_r);
    dc_mag     = nmp_pkg::mag32(cfg.disp_coef);
    vc_mag     = nmp_pkg::mag32(cfg.vel_coef);
    p1         = cfg.step_time * vel_mag;
    p2         = dc_mag * acc_mag;
    p3         = vc_mag * acc_mag;
  end

  always_comb begin
    t1 = nmp_pkg::rnd_sign({1'b0, p1_r}, n1_r);
    t2 = nm2_r ? nmp_pkg::rnd_sign(p2_r, n2_r) : 49'sd0;
    t3 = nmp_pkg::rnd_sign(p3_r, n3_r);
  end

  always_comb begin
    inc_s = nmp_pkg::sat32(inc3_r);
    inc_c = inc_s;
    if (tmp3_r) begin
      if (inc_s > nmp_pkg::TEMP_CLAMP)  inc_c = nmp_pkg::TEMP_CLAMP;
      if (inc_s < -nmp_pkg::TEMP_CLAMP) inc_c = -nmp_pkg::TEMP_CLAMP;
    end
    inc_mag  = nmp_pkg::mag32(inc_c);
    a31      = inc_mag[31] ? 31'h7FFF_FFFF : inc_mag[30:0];
    mech_upd = mech_max_r;
    temp_upd = temp_max_r;
    if (app3_r && act3_r) begin
      if (tmp3_r) begin
        if (a31 > temp_max_r) temp_upd = a31;
      end else if (a31 > mech_max_r) begin
        mech_upd = a31;
      end
    end
    nval = nmp_pkg::sat32(49'(val3_r) + 49'(inc_c));
  end

  // valid bits and running maxima
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      vo_r       <= 1'b0;
      mech_max_r <= '0;
      temp_max_r <= '0;
    end else begin
      if (en1) v1_r <= in_fire;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (eno) vo_r <= v3_r;
      if (eno && v3_r) begin
        // cleared once the last word of a pass is out
        mech_max_r <= last3_r ? 31'd0 : mech_upd;
        temp_max_r <= last3_r ? 31'd0 : temp_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_fire) begin
      slot1_r <= in_slot;
      val1_r  <= in_value;
      vel1_r  <= in_velocity;
      acc1_r  <= in_accel;
      act1_r  <= in_active;
      last1_r <= in_last;
    end
    if (en2) begin
      val2_r  <= val1_r;
      vel2_r  <= vel1_r;
      acc2_r  <= acc1_r;
      act2_r  <= act1_r;
      last2_r <= last1_r;
      app2_r  <= apply;
      nm2_r   <= newmark;
      tmp2_r  <= temp_slot;
      p1_r    <= p1;
      p2_r    <= p2;
      p3_r    <= p3;
      n1_r    <= vel1_r[31];
      n2_r    <= cfg.disp_coef[31] ^ acc1_r[31];
      n3_r    <= cfg.vel_coef[31] ^ acc1_r[31];
    end
    if (en3) begin
      val3_r  <= val2_r;
      vel3_r  <= vel2_r;
      acc3_r  <= acc2_r;
      act3_r  <= act2_r;
      last3_r <= last2_r;
      app3_r  <= app2_r;
      nm3_r   <= nm2_r;
      tmp3_r  <= tmp2_r;
      inc3_r  <= t1 + t2;
      vs3_r   <= 49'(vel2_r) + t3;
    end
    if (eno && v3_r) begin
      out_value    <= app3_r ? nval : val3_r;
      out_velocity <= (app3_r && nm3_r) ? nmp_pkg::sat32(vs3_r) : vel3_r;
      out_accel    <= (app3_r && nm3_r) ? 32'sd0 : acc3_r;
      out_max_mech <= mech_upd;
      out_max_temp <= temp_upd;
      out_last     <= last3_r;
    end
  end

endmodule

// ===== rtl/newmark_predictor_extrapolation.sv =====
// ----------------------------------------------------------------------------
// newmark_predictor_extrapolation
// Streaming Newmark predictor / static extrapolator, one freedom per word.
// ----------------------------------------------------------------------------
//
//  Channel  Dir   Handshake              Payload
//  in_      in    in_tvalid / in_tready  old value, velocity, accel; slot and
//                                        active flag in tuser; last in tlast
//  out_     out   out_tvalid/out_tready  new value, velocity, accel, maxima;
//                                        pass_done in tlast
//  cfg_     in    cfg_valid / cfg_ready  register index and write data
//
//  One word per cycle unless an output stall or the sequencer holds in_tready
//  low; a result passes product, sum and result registers behind the input
//  one. Every configuration write restarts the coefficient sequencer, which
//  holds cfg_ready and in_tready low through square, round, two partial
//  products of dt^2*(1-2*beta), final round and saturate.
//  Reset (rst_n low, synchronous) loads register defaults and zero
//  coefficients and maxima. An output stall backs up through the pipeline
//  registers; under a stall in_tready falls only once every stage is full.
//  Running maxima of |increment| go out with each word and clear after the
//  word flagged last.
//
module newmark_predictor_extrapolation (
  input  logic          clk,
  input  logic          rst_n,

  input  logic          in_tvalid,
  output logic          in_tready,
  // [31:0] old_value, [63:32] old_velocity, [95:64] old_accel
  input  logic [95:0]   in_tdata,
  // [1:0] dof_slot, [2] is_active
  input  logic [2:0]    in_tuser,
  input  logic          in_tlast,

  output logic          out_tvalid,
  input  logic          out_tready,
  // [31:0] new_value, [63:32] new_velocity, [95:64] new_accel,
  // [126:96] max_mech_change, [157:127] max_temp_change, [159:158] zero
  output logic [159:0]  out_tdata,
  output logic          out_tlast,

  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  nmp_pkg::cfg_t       cfg;
  logic                busy;
  logic                pipe_ready;
  logic                in_fire;
  logic signed [31:0]  new_value, new_velocity, new_accel;
  logic [30:0]         max_mech, max_temp;

  // no words taken while the coefficients are being rebuilt
  assign in_tready = pipe_ready && !busy;
  assign in_fire   = in_tvalid && in_tready;

  nmp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .busy      (busy),
    .cfg       (cfg)
  );

  nmp_pipe u_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_fire      (in_fire),
    .pipe_ready   (pipe_ready),
    .in_slot      (in_tuser[1:0]),
    .in_value     ($signed(in_tdata[31:0])),
    .in_velocity  ($signed(in_tdata[63:32])),
    .in_accel     ($signed(in_tdata[95:64])),
    .in_active    (in_tuser[2]),
    .in_last      (in_tlast),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_value    (new_value),
    .out_velocity (new_velocity),
    .out_accel    (new_accel),
    .out_max_mech (max_mech),
    .out_max_temp (max_temp),
    .out_last     (out_tlast)
  );

  assign out_tdata = {2'b00, max_temp, max_mech, new_accel, new_velocity, new_value};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Newmark predictor / static extrapolator.
// Each word taken on the in_ channel runs through a bit-exact Q16.16 model of
// the block. The model queues the predicted result word, and the checker
// matches it field by field against the out_ channel. Registers change only
// after the pipeline has drained. Both stream sides idle and stall at random,
// except in one steady stretch.
// ----------------------------------------------------------------------------
module testbench;

  // Thermal mode code 3 has no name of its own in the package; it acts as
  // coupled.
  localparam logic [1:0] THERM_CODE3 = 2'd3;
  localparam longint     Q_UNIT      = 65536;
  localparam longint     MAX_S32     = 64'sd2147483647;
  localparam longint     MIN_S32     = -64'sd2147483648;

  // One freedom in, one freedom out.
  typedef struct packed {
    logic [1:0]         dof_slot;
    logic signed [31:0] old_value;
    logic signed [31:0] old_velocity;
    logic signed [31:0] old_accel;
    logic               is_active;
    logic               last_item;
  } freedom_in_t;

  typedef struct packed {
    logic signed [31:0] new_value;
    logic signed [31:0] new_velocity;
    logic signed [31:0] new_accel;
    logic [30:0]        max_mech;
    logic [30:0]        max_temp;
    logic               pass_done;
  } freedom_res_t;

  logic clk = 1'b0;
  logic rst_n;

  logic         in_tvalid;
  logic         in_tready;
  logic [95:0]  in_tdata;   // [31:0] value, [63:32] velocity, [95:64] accel
  logic [2:0]   in_tuser;   // [1:0] dof_slot, [2] is_active
  logic         in_tlast;   // last freedom of the pass

  logic         out_tvalid;
  logic         out_tready;
  // [31:0] value, [63:32] velocity, [95:64] accel, [126:96] mech max,
  // [157:127] temp max
  logic [159:0] out_tdata;
  logic         out_tlast;  // pass_done

  logic               cfg_valid;
  logic               cfg_ready;
  nmp_pkg::reg_idx_t  cfg_index;
  logic [31:0]        cfg_data;

  newmark_predictor_extrapolation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: register copies, derived coefficients, running maxima
  // --------------------------------------------------------------------------
  bit          pm_dynamic;
  bit [1:0]    pm_thermal;
  bit          pm_has_prev;
  bit          pm_disc;
  bit [30:0]   pm_step;
  bit [16:0]   pm_beta;
  bit [16:0]   pm_gamma;
  longint      disp_coef;    // 0.5*(1-2*beta)*dt^2
  longint      vel_coef;     // (1-gamma)*dt
  bit [30:0]   run_mech_max;
  bit [30:0]   run_temp_max;

  freedom_res_t expected_results[$];
  int unsigned  mismatch_count = 0;
  bit           idle_on = 1'b1;   // random gaps and stalls enabled

  function automatic longint unsigned magn(longint v);
    if (v < 0) return -v;
    return v;
  endfunction

  function automatic longint clamp_s32(longint v);
    if (v > MAX_S32) return MAX_S32;
    if (v < MIN_S32) return MIN_S32;
    return v;
  endfunction

  // Q16.16 product on magnitudes, round half away from zero, then sign.
  function automatic longint fx_mul(longint a, longint b);
    longint unsigned p;
    p = (magn(a) * magn(b) + 64'd32768) >> 16;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic void derive_coefs();
    longint unsigned st, dt2, p;
    longint          m, beta_v, gamma_v, c;
    st      = pm_step;
    beta_v  = pm_beta;
    gamma_v = pm_gamma;
    // dt^2 stays unsaturated; the 0.5 factor folds into a 17-bit round
    dt2 = (st * st + 64'd32768) >> 16;
    m   = Q_UNIT - 2 * beta_v;
    p   = (dt2 * magn(m) + 64'd65536) >> 17;
    if (p > 64'h8000_0000) p = 64'h8000_0000;
    c = (m < 0) ? -longint'(p) : longint'(p);
    disp_coef = clamp_s32(c);
    vel_coef  = clamp_s32(fx_mul(Q_UNIT - gamma_v, longint'(st)));
  endfunction

  function automatic void reset_predictor();
    pm_dynamic   = 1'b0;
    pm_thermal   = nmp_pkg::THERM_MECH;
    pm_has_prev  = 1'b0;
    pm_disc      = 1'b0;
    pm_step      = '0;
    pm_beta      = 17'd16384;
    pm_gamma     = 17'd32768;
    run_mech_max = '0;
    run_temp_max = '0;
    derive_coefs();
  endfunction

  function automatic void apply_reg(nmp_pkg::reg_idx_t idx, logic [31:0] data);
    case (idx)
      nmp_pkg::REG_DYNAMIC_MODE:  pm_dynamic  = data[0];
      nmp_pkg::REG_THERMAL_MODE:  pm_thermal  = data[1:0];
      nmp_pkg::REG_HAS_PREV_INC:  pm_has_prev = data[0];
      nmp_pkg::REG_DISCONTINUITY: pm_disc     = data[0];
      nmp_pkg::REG_STEP_TIME:     pm_step     = data[30:0];
      nmp_pkg::REG_NEWMARK_BETA:  pm_beta     = data[16:0];
      nmp_pkg::REG_NEWMARK_GAMMA: pm_gamma    = data[16:0];
      default: return;
    endcase
    derive_coefs();
  endfunction

  // Expected result word for one freedom; advances the running maxima.
  function automatic freedom_res_t predict_freedom(freedom_in_t f);
    freedom_res_t    r;
    longint          val, vel, acc, st, inc;
    longint unsigned a;
    bit              therm_only, temp_slot, touched, newmark;
    val = f.old_value;
    vel = f.old_velocity;
    acc = f.old_accel;
    st  = pm_step;
    therm_only = (pm_thermal == nmp_pkg::THERM_ONLY);
    temp_slot  = (f.dof_slot == 2'd0) && (pm_thermal != nmp_pkg::THERM_MECH);
    touched    = (f.dof_slot < nmp_pkg::DOFS_PER_NODE) &&
                 (!therm_only || f.dof_slot == 2'd0);
    newmark    = pm_dynamic && !therm_only;
    r.new_value    = f.old_value;
    r.new_velocity = f.old_velocity;
    r.new_accel    = f.old_accel;
    // static mode applies the increment only past the first increment and
    // away from a load discontinuity
    if (touched && (pm_dynamic || (pm_has_prev && !pm_disc))) begin
      inc = fx_mul(st, vel);
      if (newmark) inc += fx_mul(disp_coef, acc);
      inc = clamp_s32(inc);
      if (temp_slot) begin
        if (inc > nmp_pkg::TEMP_CLAMP) inc = nmp_pkg::TEMP_CLAMP;
        if (inc < -nmp_pkg::TEMP_CLAMP) inc = -nmp_pkg::TEMP_CLAMP;
      end
      a = magn(inc);
      if (a > 64'h7FFF_FFFF) a = 64'h7FFF_FFFF;
      if (f.is_active) begin
        if (temp_slot) begin
          if (a > run_temp_max) run_temp_max = a[30:0];
        end else if (a > run_mech_max) begin
          run_mech_max = a[30:0];
        end
      end
      r.new_value = 32'(clamp_s32(val + inc));
      if (newmark) begin
        r.new_velocity = 32'(clamp_s32(vel + fx_mul(vel_coef, acc)));
        r.new_accel    = '0;
      end
    end
    r.max_mech  = run_mech_max;
    r.max_temp  = run_temp_max;
    r.pass_done = f.last_item;
    if (f.last_item) begin
      run_mech_max = '0;
      run_temp_max = '0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: sampled at the rising edge
  // --------------------------------------------------------------------------
  task automatic log_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) log_failure($sformatf("%s expected %0d, got %0d", name, want, got));
  endtask

  always @(posedge clk) begin
    freedom_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        log_failure("result word with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("new_value", want.new_value, $signed(out_tdata[31:0]));
        check_field("new_velocity", want.new_velocity, $signed(out_tdata[63:32]));
        check_field("new_accel", want.new_accel, $signed(out_tdata[95:64]));
        check_field("max_mech_change", want.max_mech, out_tdata[126:96]);
        check_field("max_temp_change", want.max_temp, out_tdata[157:127]);
        check_field("pass_done", want.pass_done, out_tlast);
      end
    end
  end

  // Receiver backpressure, driven at the falling edge.
  always @(negedge clk) begin
    out_tready <= !idle_on || ($urandom_range(99) >= 15);
  end

  // --------------------------------------------------------------------------
  // Drivers: every task starts and ends at a falling edge
  // --------------------------------------------------------------------------
  function automatic freedom_in_t make_freedom(logic [1:0] slot, logic signed [31:0] val,
                                               logic signed [31:0] vel,
                                               logic signed [31:0] acc,
                                               logic active, logic last);
    freedom_in_t f;
    f.dof_slot     = slot;
    f.old_value    = val;
    f.old_velocity = vel;
    f.old_accel    = acc;
    f.is_active    = active;
    f.last_item    = last;
    return f;
  endfunction

  task automatic send_freedom(freedom_in_t f);
    if (idle_on && $urandom_range(99) < 15) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {f.old_accel, f.old_velocity, f.old_value};
    in_tuser  <= {f.is_active, f.dof_slot};
    in_tlast  <= f.last_item;
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(predict_freedom(f));
    @(negedge clk);
  endtask

  // Sender holds off until every queued result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(nmp_pkg::reg_idx_t idx, logic [31:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mix of saturation extremes, tiny values, mid-range and full-range words.
  function automatic logic signed [31:0] rand_q();
    int s;
    case ($urandom_range(7))
      0: return nmp_pkg::S32_MAX;
      1: return nmp_pkg::S32_MIN;
      2: begin
        s = $urandom_range(2);
        return s - 1;
      end
      3, 4, 5: return $signed($urandom()) >>> $urandom_range(31, 8);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [16:0] rand_coef17();
    case ($urandom_range(6))
      0: return 17'd0;
      1: return 17'd16384;
      2: return 17'd32768;
      3: return 17'd65536;
      4: return 17'h1FFFF;
      5: return 17'($urandom_range(65536));
      default: return 17'($urandom());
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset state is static without a previous increment: all pass through.
  task automatic test_reset_defaults();
    send_freedom(make_freedom(2'd1, nmp_pkg::S32_MAX, nmp_pkg::S32_MIN, 32'sd12345,
                              1'b1, 1'b0));
    send_freedom(make_freedom(2'd0, nmp_pkg::S32_MIN, nmp_pkg::S32_MAX, -32'sd1,
                              1'b1, 1'b1));
  endtask

  // Static extrapolation: saturation at the widest step, rounding ties at
  // half a unit, inactive freedom kept out of the maxima.
  task automatic test_static_extrapolation();
    write_reg(nmp_pkg::REG_HAS_PREV_INC, 32'd1);
    write_reg(nmp_pkg::REG_STEP_TIME, 32'h7FFF_FFFF);
    send_freedom(make_freedom(2'd0, nmp_pkg::S32_MIN, nmp_pkg::S32_MAX, 32'sd0,
                              1'b1, 1'b0));
    // increment of -2^31: magnitude saturates for the maxima
    send_freedom(make_freedom(2'd3, 32'sd0, nmp_pkg::S32_MIN, nmp_pkg::S32_MAX,
                              1'b1, 1'b0));
    send_freedom(make_freedom(2'd2, nmp_pkg::S32_MAX, 32'sh10000, nmp_pkg::S32_MIN,
                              1'b0, 1'b0));
    write_reg(nmp_pkg::REG_STEP_TIME, 32'h8000);
    send_freedom(make_freedom(2'd1, 32'sd7, 32'sd1, 32'sd0, 1'b1, 1'b0));
    send_freedom(make_freedom(2'd2, -32'sd7, -32'sd1, 32'sd0, 1'b1, 1'b0));
    send_freedom(make_freedom(2'd3, 32'sd0, 32'sd3, 32'sd0, 1'b1, 1'b1));
  endtask

  // A flagged discontinuity suppresses the static increment.
  task automatic test_discontinuity();
    write_reg(nmp_pkg::REG_DISCONTINUITY, 32'd1);
    send_freedom(make_freedom(2'd1, 32'sd100, nmp_pkg::S32_MAX, 32'sd5, 1'b1, 1'b0));
    send_freedom(make_freedom(2'd0, -32'sd100, nmp_pkg::S32_MIN, -32'sd5, 1'b1, 1'b1));
    write_reg(nmp_pkg::REG_DISCONTINUITY, 32'd0);
  endtask

  // Newmark with beta and gamma at 0, at 1.0 and at the top of the field,
  // then thermal-only in dynamic mode.
  task automatic test_dynamic_newmark();
    write_reg(nmp_pkg::REG_DYNAMIC_MODE, 32'd1);
    write_reg(nmp_pkg::REG_STEP_TIME, 32'h10000);
    write_reg(nmp_pkg::REG_NEWMARK_BETA, 32'd0);
    write_reg(nmp_pkg::REG_NEWMARK_GAMMA, 32'd0);
    send_freedom(make_freedom(2'd1, 32'sh10000, 32'sh20000, 32'sh40000, 1'b1, 1'b0));
    send_freedom(make_freedom(2'd0, 32'sd0, -32'sh10000, -32'sh38000, 1'b1, 1'b0));
    write_reg(nmp_pkg::REG_NEWMARK_BETA, 32'd65536);
    write_reg(nmp_pkg::REG_NEWMARK_GAMMA, 32'd65536);
    send_freedom(make_freedom(2'd2, 32'sh10000, 32'sh8000, 32'sh30000, 1'b1, 1'b0));
    send_freedom(make_freedom(2'd3, -32'sh10000, 32'sd1, -32'sd3, 1'b1, 1'b0));
    write_reg(nmp_pkg::REG_STEP_TIME, 32'h7FFF_FFFF);
    write_reg(nmp_pkg::REG_NEWMARK_BETA, 32'h1FFFF);
    write_reg(nmp_pkg::REG_NEWMARK_GAMMA, 32'h1FFFF);
    send_freedom(make_freedom(2'd2, nmp_pkg::S32_MAX, nmp_pkg::S32_MAX, nmp_pkg::S32_MIN,
                              1'b1, 1'b0));
    send_freedom(make_freedom(2'd3, nmp_pkg::S32_MIN, nmp_pkg::S32_MIN, nmp_pkg::S32_MAX,
                              1'b1, 1'b1));
    write_reg(nmp_pkg::REG_STEP_TIME, 32'h18000);
    write_reg(nmp_pkg::REG_THERMAL_MODE, 32'(nmp_pkg::THERM_ONLY));
    send_freedom(make_freedom(2'd0, 32'sh10000, 32'sh50000, 32'sh70000, 1'b1, 1'b0));
    send_freedom(make_freedom(2'd2, 32'sh10000, 32'sh50000, 32'sh70000, 1'b1, 1'b1));
  endtask

  // Temperature increment clamp at +-100.0, coupled maxima split, and
  // thermal mode code 3 acting as coupled.
  task automatic test_thermal_clamp();
    write_reg(nmp_pkg::REG_DYNAMIC_MODE, 32'd0);
    write_reg(nmp_pkg::REG_THERMAL_MODE, 32'(nmp_pkg::THERM_COUPLED));
    write_reg(nmp_pkg::REG_STEP_TIME, 32'h10000);
    send_freedom(make_freedom(2'd0, 32'sd0, 32'sd13107200, 32'sd1, 1'b1, 1'b0));
    send_freedom(make_freedom(2'd0, 32'sd0, -32'sd13107200, 32'sd1, 1'b1, 1'b0));
    send_freedom(make_freedom(2'd1, 32'sd0, 32'sh50000, 32'sd1, 1'b1, 1'b0));
    send_freedom(make_freedom(2'd0, nmp_pkg::S32_MAX, 32'sd19660800, 32'sd0, 1'b0, 1'b0));
    write_reg(nmp_pkg::REG_THERMAL_MODE, 32'(THERM_CODE3));
    send_freedom(make_freedom(2'd0, nmp_pkg::S32_MIN, -32'sd9830400, 32'sd0, 1'b1, 1'b1));
  endtask

  // Random register settings per phase, then passes of whole nodes with
  // random content; a few stray slots and early last flags as noise.
  task automatic test_random_passes(int unsigned target);
    int unsigned sent;
    int unsigned count;
    logic [30:0] st;
    logic [1:0]  slot;
    logic        last;
    sent = 0;
    while (sent < target) begin
      case ($urandom_range(4))
        0: st = 31'd0;
        1: st = 31'h7FFF_FFFF;
        2: st = 31'($urandom_range(32'h1000));
        3: st = 31'($urandom_range(32'h40000));
        default: st = 31'($urandom());
      endcase
      write_reg(nmp_pkg::REG_DYNAMIC_MODE, $urandom_range(1));
      write_reg(nmp_pkg::REG_THERMAL_MODE, $urandom_range(3));
      write_reg(nmp_pkg::REG_HAS_PREV_INC, 32'($urandom_range(3) != 0));
      write_reg(nmp_pkg::REG_DISCONTINUITY, 32'($urandom_range(3) == 0));
      write_reg(nmp_pkg::REG_STEP_TIME, {1'($urandom_range(1)), st});
      write_reg(nmp_pkg::REG_NEWMARK_BETA, 32'(rand_coef17()));
      write_reg(nmp_pkg::REG_NEWMARK_GAMMA, 32'(rand_coef17()));
      count = 4 * $urandom_range(30, 1);
      for (int unsigned k = 0; k < count; k++) begin
        slot = ($urandom_range(7) == 0) ? 2'($urandom()) : 2'(k);
        last = (k == count - 1) || ($urandom_range(49) == 0);
        send_freedom(make_freedom(slot, rand_q(), rand_q(), rand_q(),
                                  ($urandom_range(7) != 0), last));
        sent++;
      end
    end
  endtask

  // Back-to-back words and no output stalls for a long stretch.
  task automatic test_steady_stream();
    idle_on = 1'b0;
    test_random_passes(150);
    drain_results();
    idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = nmp_pkg::REG_DYNAMIC_MODE;
    cfg_data   = '0;
    reset_predictor();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_static_extrapolation();
    test_discontinuity();
    test_dynamic_newmark();
    test_thermal_clamp();
    test_random_passes(860);
    test_steady_stream();

    drain_results();
    // pipeline is four deep; leave room for any stray word
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nmp_pkg.sv
rtl/nmp_cfg.sv
rtl/nmp_pipe.sv
rtl/newmark_predictor_extrapolation.sv
tb/sv/testbench.sv
